// File: design/assert_macros.svh
// Assertion macros shared by the design files.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/ffba_pkg.sv
// Package for the first-fit block allocator: sizes, codes, payload types.
// No dependencies.
package ffba_pkg;
    localparam int HEAP_GRANULES = 1024;
    localparam int GRANULE_BYTES = 64;
    localparam int HEADER_BYTES  = 12;
    localparam int GW  = $clog2(HEAP_GRANULES);
    localparam int LW  = $clog2(HEAP_GRANULES + 1);
    localparam int BW  = $clog2(GRANULE_BYTES);
    localparam int FBW = 17;
    localparam logic [31:0] BASE_RESET = 32'h0020_0000;
    localparam logic [FBW-1:0] HEAP_BYTES = FBW'(HEAP_GRANULES * GRANULE_BYTES);

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_BADREL = 2'd2
    } t_status;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] request_bytes;
        logic [31:0] release_address;
    } t_cmd;

    typedef struct packed {
        logic [1:0]     status;
        logic [31:0]    block_address;
        logic [FBW-1:0] free_bytes;
    } t_result;

    typedef struct packed {
        logic [LW-1:0] len;
        logic          used;
    } t_entry;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_A_RD, S_A_CHK, S_R_RD, S_R_CHK, S_R_NX, S_R_WLK,
        S_R_PCHK, S_FIN
    } t_state;
endpackage

// File: design/first_fit_block_allocator.sv
// First-fit heap allocator with coalescing, top level.
// Depends on ffba_pkg and assert_macros.svh.
//
// Channel   Direction  Signals
// command   in         start, busy, i_cmd
// result    out        o_strobe, o_result
// config    in         i_cfg_we, i_cfg_wdata (heap_base)
//
// An allocate walks the block table one block at a time (read, then check),
// holding busy until it finds a fit or fails. A release reads its block and
// next neighbour, then walks from granule zero to find the predecessor,
// holding busy until it is done. After reset a clearing pass zeroes the
// table but for granule zero, which gets one free block spanning the heap;
// busy stays high. The receiver cannot stall: each result is shown for one
// cycle on o_strobe, in the first cycle with busy low.
`include "assert_macros.svh"
module first_fit_block_allocator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ffba_pkg::t_cmd       i_cmd,
    output logic                 o_strobe,
    output ffba_pkg::t_result    o_result,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata
);
    localparam int GW = ffba_pkg::GW;
    localparam int LW = ffba_pkg::LW;
    localparam int BW = ffba_pkg::BW;
    localparam int FBW = ffba_pkg::FBW;

    // Block table: one synchronous memory, one read and one write port.
    ffba_pkg::t_entry mem [ffba_pkg::HEAP_GRANULES];
    ffba_pkg::t_entry r_rdata;
    logic [GW-1:0]    rd_addr;
    logic             wr_en;
    logic [GW-1:0]    wr_addr;
    ffba_pkg::t_entry wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    ffba_pkg::t_state r_state, n_state;
    logic [31:0]    r_base;
    logic [FBW-1:0] r_used, n_used;
    logic [LW-1:0]  r_g, n_g;       // walk pointer / cleared count
    logic [LW-1:0]  r_need, n_need; // granules wanted
    logic [GW-1:0]  r_tg, n_tg;     // released block
    logic [LW-1:0]  r_tlen, n_tlen; // released block length after merge
    logic [GW-1:0]  r_prev, n_prev;
    logic           r_hprev, n_hprev;
    logic [31:0]    r_arg;
    logic           n_strobe, r_strobe;
    ffba_pkg::t_result n_res, r_res;

    // Allocate sizing: granules = ceil(max(req+hdr, G)/G); saturate when big.
    logic [32:0] need_b;
    logic [32-BW:0] need_g;
    always_comb begin
        need_b = {1'b0, r_arg} + 33'(ffba_pkg::HEADER_BYTES)
               + 33'(ffba_pkg::GRANULE_BYTES - 1);
        need_g = need_b[32:BW];
        if (need_g == '0) need_g = (33-BW)'(1);
    end
    logic [LW-1:0] need_sat;
    assign need_sat = (need_g > (33-BW)'(ffba_pkg::HEAP_GRANULES))
                    ? LW'(ffba_pkg::HEAP_GRANULES) : LW'(need_g);
    logic need_big;
    assign need_big = need_g > (33-BW)'(ffba_pkg::HEAP_GRANULES);

    // Release decoding.
    logic [31:0] off;
    assign off = r_arg - 32'(ffba_pkg::HEADER_BYTES) - r_base;
    logic rel_bad;
    assign rel_bad = (r_arg == '0) || (off[BW-1:0] != '0)
                   || (off[31:BW] >= (32-BW)'(ffba_pkg::HEAP_GRANULES));

    // Split when remainder >= G+H bytes, i.e. at least 2 granules for H>0.
    localparam int SPLIT_G = (ffba_pkg::GRANULE_BYTES + ffba_pkg::HEADER_BYTES
                              + ffba_pkg::GRANULE_BYTES - 1) / ffba_pkg::GRANULE_BYTES;

    logic [LW-1:0] rem;
    assign rem = r_rdata.len - r_need;
    logic [LW-1:0] nx;
    assign nx = LW'(r_tg) + r_rdata.len;
    logic [LW-1:0] walk_nx;
    assign walk_nx = r_g + r_rdata.len;

    always_comb begin
        n_state = r_state; n_used = r_used; n_g = r_g; n_need = r_need;
        n_tg = r_tg; n_tlen = r_tlen; n_prev = r_prev; n_hprev = r_hprev;
        n_strobe = 1'b0;
        n_res = r_res;
        rd_addr = r_g[GW-1:0];
        wr_en = 1'b0; wr_addr = r_g[GW-1:0]; wr_data = '0;
        unique case (r_state)
            ffba_pkg::S_CLEAR: begin
                wr_en = 1'b1;
                wr_data.len = (r_g == '0) ? LW'(ffba_pkg::HEAP_GRANULES) : '0;
                n_g = r_g + 1'b1;
                if (r_g == LW'(ffba_pkg::HEAP_GRANULES - 1)) n_state = ffba_pkg::S_IDLE;
            end
            ffba_pkg::S_IDLE: begin
                if (start) begin
                    n_state = (i_cmd.opcode == ffba_pkg::OP_ALLOC)
                            ? ffba_pkg::S_A_RD : ffba_pkg::S_R_RD;
                    n_g = '0;
                end
            end
            ffba_pkg::S_A_RD: begin
                n_need = need_sat;
                if (need_big || r_g >= LW'(ffba_pkg::HEAP_GRANULES)) begin
                    n_res = '{ffba_pkg::ST_NOFIT, 32'd0, ffba_pkg::HEAP_BYTES - r_used};
                    n_strobe = 1'b1; n_state = ffba_pkg::S_IDLE;
                end else begin
                    n_state = ffba_pkg::S_A_CHK;
                end
            end
            ffba_pkg::S_A_CHK: begin
                if (r_rdata.len == '0) begin
                    n_res = '{ffba_pkg::ST_NOFIT, 32'd0, ffba_pkg::HEAP_BYTES - r_used};
                    n_strobe = 1'b1; n_state = ffba_pkg::S_IDLE;
                end else if (!r_rdata.used && r_rdata.len >= r_need) begin
                    wr_en = 1'b1;
                    wr_data.used = 1'b1;
                    if (rem >= LW'(SPLIT_G)) begin
                        wr_data.len = r_need;
                        n_tlen = rem;
                        n_tg = GW'(r_g + r_need);
                        n_state = ffba_pkg::S_FIN;
                    end else begin
                        wr_data.len = r_rdata.len;
                        n_state = ffba_pkg::S_IDLE;
                        n_strobe = 1'b1;
                    end
                    n_used = r_used + (FBW'(wr_data.len) << BW);
                    n_res = '{ffba_pkg::ST_DONE,
                              r_base + (32'(r_g) << BW) + 32'(ffba_pkg::HEADER_BYTES),
                              ffba_pkg::HEAP_BYTES - n_used};
                end else begin
                    n_g = walk_nx;
                    n_state = ffba_pkg::S_A_RD;
                end
            end
            ffba_pkg::S_FIN: begin
                // Write the split-off free remainder, or clear the released entry after a merge.
                wr_en = 1'b1; wr_addr = r_tg;
                wr_data.len = r_tlen;
                n_strobe = 1'b1; n_state = ffba_pkg::S_IDLE;
            end
            ffba_pkg::S_R_RD: begin
                rd_addr = off[GW+BW-1:BW];
                n_tg = off[GW+BW-1:BW];
                if (rel_bad) begin
                    n_res = '{ffba_pkg::ST_BADREL, 32'd0, ffba_pkg::HEAP_BYTES - r_used};
                    n_strobe = 1'b1; n_state = ffba_pkg::S_IDLE;
                end else n_state = ffba_pkg::S_R_CHK;
            end
            ffba_pkg::S_R_CHK: begin
                rd_addr = nx[GW-1:0];
                n_tlen = r_rdata.len;
                if (r_rdata.len == '0 || !r_rdata.used) begin
                    n_res = '{ffba_pkg::ST_BADREL, 32'd0, ffba_pkg::HEAP_BYTES - r_used};
                    n_strobe = 1'b1; n_state = ffba_pkg::S_IDLE;
                end else begin
                    n_used = r_used - (FBW'(r_rdata.len) << BW);
                    wr_en = 1'b1; wr_addr = r_tg; wr_data.len = r_rdata.len;
                    n_state = (nx < LW'(ffba_pkg::HEAP_GRANULES))
                            ? ffba_pkg::S_R_NX : ffba_pkg::S_R_WLK;
                    n_g = '0; n_hprev = 1'b0;
                end
            end
            ffba_pkg::S_R_NX: begin
                // Merge with a free next neighbour.
                rd_addr = '0;
                if (r_rdata.len != '0 && !r_rdata.used) begin
                    wr_en = 1'b1; wr_addr = GW'(LW'(r_tg) + r_tlen);
                    wr_data = '0;
                    n_tlen = r_tlen + r_rdata.len;
                end
                n_state = ffba_pkg::S_R_WLK;
            end
            ffba_pkg::S_R_WLK: begin
                // Reads r_g (r_prev once r_g >= r_tg) this cycle; checked next.
                n_state = ffba_pkg::S_R_PCHK;
                if (r_g >= LW'(r_tg)) begin
                    rd_addr = r_prev;
                end
                wr_en = 1'b1; wr_addr = r_tg; wr_data.len = r_tlen;
            end
            ffba_pkg::S_R_PCHK: begin
                if (r_g < LW'(r_tg) && r_rdata.len != '0) begin
                    n_prev = r_g[GW-1:0]; n_hprev = 1'b1;
                    n_g = walk_nx;
                    n_state = ffba_pkg::S_R_WLK;
                end else begin
                    // r_rdata here is stale; re-read predecessor next.
                    if (r_g < LW'(r_tg) || !r_hprev || r_g != walk_nx) begin
                        n_state = ffba_pkg::S_R_WLK;
                    end
                    n_g = LW'(ffba_pkg::HEAP_GRANULES);
                    if (r_hprev && r_g == LW'(ffba_pkg::HEAP_GRANULES)
                        && !r_rdata.used && LW'(r_prev) + r_rdata.len == LW'(r_tg)) begin
                        wr_en = 1'b1; wr_addr = r_prev;
                        wr_data.len = r_rdata.len + r_tlen;
                        n_tlen = '0;
                        n_state = ffba_pkg::S_FIN;
                    end else if (r_g == LW'(ffba_pkg::HEAP_GRANULES)) begin
                        n_strobe = 1'b1; n_state = ffba_pkg::S_IDLE;
                    end
                    n_res = '{ffba_pkg::ST_DONE, 32'd0, ffba_pkg::HEAP_BYTES - r_used};
                end
            end
            default: n_state = ffba_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::S_CLEAR;
            r_base <= ffba_pkg::BASE_RESET;
            r_used <= '0; r_g <= '0; r_strobe <= 1'b0; r_hprev <= 1'b0;
        end else begin
            r_state <= n_state; r_used <= n_used; r_g <= n_g;
            r_strobe <= n_strobe; r_hprev <= n_hprev;
            if (i_cfg_we) r_base <= i_cfg_wdata;
        end
        r_need <= n_need; r_tg <= n_tg; r_tlen <= n_tlen; r_prev <= n_prev;
        r_res <= n_res;
        if (r_state == ffba_pkg::S_IDLE && start) begin
            r_arg <= (i_cmd.opcode == ffba_pkg::OP_ALLOC)
                   ? i_cmd.request_bytes : i_cmd.release_address;
        end
    end

    assign busy = (r_state != ffba_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_IMPLIES(a_used_range, i_clk, i_rst_n, 1'b1, r_used <= ffba_pkg::HEAP_BYTES)
    `ASSERT_IMPLIES(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
endmodule

// File: bench/first_fit_block_allocator_tb.sv
// Self-checking testbench for the first-fit block allocator.
// Depends on ffba_pkg and the first_fit_block_allocator top level.
module first_fit_block_allocator_tb;
    import ffba_pkg::*;

    localparam int LAT = 2 * HEAP_GRANULES + 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        i_cmd;
    logic        o_strobe;
    t_result     o_result;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    first_fit_block_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Shadow heap: block length per granule (0 where no block starts) and the used flag.
    int unsigned blk_len [HEAP_GRANULES];
    bit          blk_used[HEAP_GRANULES];
    int unsigned held_bytes;
    logic [31:0] shadow_base;

    t_cmd        pending_cmds[$];
    t_result     expected_results[$];
    logic [31:0] live_addrs[$];
    int          mismatches;
    bit          drv_active;
    int          gap_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Time limit: every item at the full table walk, plus long gaps, several times over.
    initial begin
        #(4 * 1200 * (LAT + 200) * 3);
        $display("Mismatches found");
        $finish;
    end

    function automatic t_result make_result(logic [1:0] st, logic [31:0] addr);
        t_result r;
        r.status        = st;
        r.block_address = addr;
        r.free_bytes    = HEAP_BYTES - held_bytes[FBW-1:0];
        return r;
    endfunction

    function automatic t_result predict_alloc(logic [31:0] req);
        longint unsigned need;
        int unsigned     g;
        int unsigned     len;
        int unsigned     take;
        need = longint'(req) + HEADER_BYTES;
        if (need < GRANULE_BYTES) need = GRANULE_BYTES;
        need = (need + GRANULE_BYTES - 1) / GRANULE_BYTES * GRANULE_BYTES;
        g = 0;
        while (g < HEAP_GRANULES) begin
            len = blk_len[g];
            if (len == 0) break;
            if (!blk_used[g] && longint'(len) * GRANULE_BYTES >= need) begin
                take = need / GRANULE_BYTES;
                if (longint'(len) * GRANULE_BYTES >= need + GRANULE_BYTES + HEADER_BYTES)
                begin
                    blk_len[g]         = take;
                    blk_len[g + take]  = len - take;
                    blk_used[g + take] = 1'b0;
                end
                blk_used[g] = 1'b1;
                held_bytes += blk_len[g] * GRANULE_BYTES;
                return make_result(ST_DONE, shadow_base + 32'(g * GRANULE_BYTES)
                                   + 32'(HEADER_BYTES));
            end
            g += len;
        end
        return make_result(ST_NOFIT, 32'd0);
    endfunction

    function automatic t_result predict_release(logic [31:0] addr);
        logic [31:0] off;
        int unsigned g;
        int unsigned len;
        int unsigned nx;
        int unsigned p;
        int unsigned prev;
        bit          have_prev;
        if (addr == 32'd0) return make_result(ST_BADREL, 32'd0);
        off = addr - 32'(HEADER_BYTES) - shadow_base;
        if (off % GRANULE_BYTES != 0 || off / GRANULE_BYTES >= HEAP_GRANULES)
            return make_result(ST_BADREL, 32'd0);
        g = off / GRANULE_BYTES;
        if (blk_len[g] == 0 || !blk_used[g]) return make_result(ST_BADREL, 32'd0);
        len = blk_len[g];
        blk_used[g] = 1'b0;
        held_bytes -= len * GRANULE_BYTES;
        nx = g + len;
        if (nx < HEAP_GRANULES && blk_len[nx] != 0 && !blk_used[nx]) begin
            blk_len[g]  = len + blk_len[nx];
            blk_len[nx] = 0;
        end
        // Find the block immediately below this one so it can absorb the freed space.
        prev = 0;
        have_prev = 1'b0;
        p = 0;
        while (p < g) begin
            if (blk_len[p] == 0) break;
            prev = p;
            have_prev = 1'b1;
            p += blk_len[p];
        end
        if (have_prev && !blk_used[prev] && prev + blk_len[prev] == g) begin
            blk_len[prev] += blk_len[g];
            blk_len[g] = 0;
        end
        return make_result(ST_DONE, 32'd0);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic t_cmd alloc_cmd(logic [31:0] req);
        t_cmd c;
        c.opcode          = OP_ALLOC;
        c.request_bytes   = req;
        c.release_address = $urandom;
        return c;
    endfunction

    function automatic t_cmd release_cmd(logic [31:0] addr);
        t_cmd c;
        c.opcode          = OP_RELEASE;
        c.request_bytes   = $urandom;
        c.release_address = addr;
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Driver: issue one transaction from the queue whenever the block is free and no
    // gap is pending. start is held until acceptance, never dropped and raised in one step.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_results.push_back(i_cmd.opcode == OP_ALLOC ?
                    predict_alloc(i_cmd.request_bytes) :
                    predict_release(i_cmd.release_address));
                if (i_cmd.opcode == OP_ALLOC && expected_results[$].status == ST_DONE &&
                    expected_results[$].block_address != 32'd0)
                    live_addrs.push_back(expected_results[$].block_address);
                gap_left = pick_gap();
                if (gap_left == 0 && drv_active && pending_cmds.size() > 0) begin
                    i_cmd <= pending_cmds.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end else if (!start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (drv_active && pending_cmds.size() > 0) begin
                    i_cmd <= pending_cmds.pop_front();
                    start <= 1'b1;
                end
            end
        end
    end

    // Monitor: every strobe must match the oldest expectation, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_result.block_address, 32'd0);
            end else begin
                automatic t_result want = expected_results.pop_front();
                if (o_result.status != want.status)
                    report_mismatch("status", 32'(o_result.status), 32'(want.status));
                if (o_result.block_address != want.block_address)
                    report_mismatch("block_address", o_result.block_address,
                                    want.block_address);
                if (o_result.free_bytes != want.free_bytes)
                    report_mismatch("free_bytes", 32'(o_result.free_bytes),
                                    32'(want.free_bytes));
            end
        end
    end

    // Run one batch through the driver and wait for every result plus the settling time.
    task automatic run_batch();
        drv_active = 1'b1;
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    task automatic write_base(logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_base = value;
    endtask

    // Random mix: mostly allocations and releases of live blocks, some invalid releases.
    task automatic queue_random(int count);
        int r;
        int k;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                if ($urandom_range(0, 19) == 0)
                    pending_cmds.push_back(alloc_cmd($urandom));
                else if ($urandom_range(0, 3) == 0)
                    pending_cmds.push_back(alloc_cmd($urandom_range(0, 8000)));
                else
                    pending_cmds.push_back(alloc_cmd($urandom_range(0, 400)));
            end else if (r < 85 && live_addrs.size() > 0) begin
                k = $urandom_range(0, live_addrs.size() - 1);
                pending_cmds.push_back(release_cmd(live_addrs[k]));
                live_addrs.delete(k);
            end else begin
                pending_cmds.push_back(release_cmd(shadow_base + 32'(HEADER_BYTES) +
                    32'($urandom_range(0, HEAP_GRANULES + 4) * GRANULE_BYTES) +
                    32'($urandom_range(0, 1) * $urandom_range(1, 63))));
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        drv_active  = 1'b0;
        gap_left    = 0;
        mismatches  = 0;
        held_bytes  = 0;
        shadow_base = BASE_RESET;
        foreach (blk_len[i]) begin
            blk_len[i]  = 0;
            blk_used[i] = 1'b0;
        end
        blk_len[0] = HEAP_GRANULES;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset base, extremes, splitting boundary, whole-block use, coalescing.
        pending_cmds.push_back(alloc_cmd(32'd0));
        pending_cmds.push_back(alloc_cmd(32'd52));
        pending_cmds.push_back(alloc_cmd(32'd53));
        pending_cmds.push_back(alloc_cmd(32'hFFFF_FFFF));
        pending_cmds.push_back(alloc_cmd(32'(HEAP_GRANULES * GRANULE_BYTES)));
        pending_cmds.push_back(release_cmd(BASE_RESET + 32'(HEADER_BYTES)));
        pending_cmds.push_back(release_cmd(BASE_RESET + 32'(HEADER_BYTES)));
        pending_cmds.push_back(release_cmd(32'd0));
        pending_cmds.push_back(release_cmd(BASE_RESET + 32'(HEADER_BYTES) + 32'd1));
        pending_cmds.push_back(release_cmd(BASE_RESET + 32'(HEADER_BYTES) +
                                           32'(HEAP_GRANULES * GRANULE_BYTES)));
        pending_cmds.push_back(release_cmd(BASE_RESET + 32'(HEADER_BYTES + GRANULE_BYTES)));
        pending_cmds.push_back(release_cmd(BASE_RESET + 32'(HEADER_BYTES + 3 * GRANULE_BYTES)));
        pending_cmds.push_back(alloc_cmd(32'(HEAP_GRANULES * GRANULE_BYTES - HEADER_BYTES - 192)));
        pending_cmds.push_back(alloc_cmd(32'd100));
        pending_cmds.push_back(alloc_cmd(32'hDEADBEEF));
        run_batch();
        // Free what remains live so later phases start from known space.
        live_addrs.delete();
        for (int g = 0; g < HEAP_GRANULES; g++)
            if (blk_len[g] != 0 && blk_used[g])
                pending_cmds.push_back(release_cmd(shadow_base + 32'(g * GRANULE_BYTES)
                                                   + 32'(HEADER_BYTES)));
        run_batch();

        // Whole heap wraps the address space: an allocate landing on zero reports zero.
        write_base(32'hFFFF_FFF4);
        pending_cmds.push_back(alloc_cmd(32'd10));
        pending_cmds.push_back(alloc_cmd(32'd10));
        run_batch();
        queue_random(100);
        run_batch();

        write_base(32'h0000_0000);
        queue_random(100);
        run_batch();
        write_base($urandom);
        queue_random(100);
        run_batch();
        write_base(32'h0080_0000);
        queue_random(100);
        run_batch();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
